>>> rtl/core/mpsm_pkg.sv
// ----------------------------------------------------------------------------
// mpsm_pkg: shared types and codes of the multi-pattern string matcher
// Holds the action and status codes, the controller states, the datapath
// micro-operations and the control/status bundles between the two.
// ----------------------------------------------------------------------------
package mpsm_pkg;

	localparam int ID_W        = 4;
	localparam int MAX_RESULTS = 16;
	localparam int NCNT_W      = $clog2(MAX_RESULTS);

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_BUILD = 2'd2,
		ACT_SCAN  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_MATCH         = 3'd1,
		ST_NOMATCH       = 3'd2,
		ST_STATES_FULL   = 3'd3,
		ST_PATTERNS_FULL = 3'd4,
		ST_WRONG_PHASE   = 3'd5
	} status_t;

	typedef enum logic [4:0] {
		S_SWEEP_RST, S_IDLE, S_CLR, S_SWEEP_CLR, S_EMIT,
		S_ADD, S_ADD_EV, S_ADD_OWN,
		S_B0, S_B1_RD, S_B1_EV,
		S_B2_POP, S_B2_R, S_B2_FR, S_B2_RD, S_B2_EV, S_B2_NEXT,
		S_B2_WALK, S_B2_FAIL, S_B2_OUT,
		S_SC, S_SC_EV, S_SC_FAIL, S_SC_OWN, S_SC_CH, S_EMIT_M
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_ACCEPT, OP_CLR, OP_SWEEP, OP_EMIT,
		OP_ADD, OP_ADD_EV, OP_ADD_OWN,
		OP_B0, OP_B1_RD, OP_B1_EV,
		OP_B2_POP, OP_B2_R, OP_B2_FR, OP_B2_RD, OP_B2_EV, OP_B2_NEXT,
		OP_B2_WALK, OP_B2_FAIL, OP_B2_OUT,
		OP_SC, OP_SC_EV, OP_SC_FAIL, OP_SC_OWN, OP_SC_CH, OP_EMIT_M
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic built;
		logic dropped;
		logic add_drop;
		logic last;
		logic q_empty;
		logic chr_last;
		logic g_absent;
		logic own_none;
		logic link_none;
		logic res_last;
		logic out_free;
	} stat_t;

endpackage

>>> rtl/core/mpsm_ram.sv
// ----------------------------------------------------------------------------
// mpsm_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module mpsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/mpsm_ctrl.sv
// ----------------------------------------------------------------------------
// mpsm_ctrl: sequencing state machine of the matcher
// Walks each item through its micro-operations and issues one datapath
// command per cycle, steered by the datapath status.
// ----------------------------------------------------------------------------
module mpsm_ctrl import mpsm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  action_t in_action,
	output logic    in_ready,
	input  stat_t   stat,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP_RST;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_SWEEP_RST: if (stat.sweep_done) state_d = S_IDLE;
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_action)
						ACT_CLEAR: state_d = S_CLR;
						ACT_ADD:   state_d = S_ADD;
						ACT_BUILD: state_d = S_B0;
						ACT_SCAN:  state_d = S_SC;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_CLR:       state_d = S_SWEEP_CLR;
			S_SWEEP_CLR: if (stat.sweep_done) state_d = S_EMIT;
			S_EMIT:      if (stat.out_free) state_d = S_IDLE;
			S_ADD:       state_d = (stat.built || stat.dropped) ? S_EMIT : S_ADD_EV;
			S_ADD_EV:    state_d = (stat.last && !stat.add_drop) ? S_ADD_OWN : S_EMIT;
			S_ADD_OWN:   state_d = S_EMIT;
			S_B0:        state_d = stat.built ? S_EMIT : S_B1_RD;
			S_B1_RD:     state_d = S_B1_EV;
			S_B1_EV:     state_d = stat.chr_last ? S_B2_POP : S_B1_RD;
			S_B2_POP:    state_d = stat.q_empty ? S_EMIT : S_B2_R;
			S_B2_R:      state_d = S_B2_FR;
			S_B2_FR:     state_d = S_B2_RD;
			S_B2_RD:     state_d = S_B2_EV;
			S_B2_EV: begin
				if (!stat.g_absent) state_d = S_B2_WALK;
				else state_d = stat.chr_last ? S_B2_POP : S_B2_NEXT;
			end
			S_B2_NEXT:   state_d = S_B2_RD;
			S_B2_WALK:   state_d = stat.g_absent ? S_B2_FAIL : S_B2_OUT;
			S_B2_FAIL:   state_d = S_B2_WALK;
			S_B2_OUT:    state_d = stat.chr_last ? S_B2_POP : S_B2_NEXT;
			S_SC:        state_d = stat.built ? S_SC_EV : S_EMIT;
			S_SC_EV:     state_d = stat.g_absent ? S_SC_FAIL : S_SC_OWN;
			S_SC_FAIL:   state_d = S_SC_EV;
			S_SC_OWN: begin
				if (!stat.own_none) state_d = S_EMIT_M;
				else state_d = stat.link_none ? S_EMIT : S_SC_CH;
			end
			S_SC_CH:     state_d = S_EMIT_M;
			S_EMIT_M: begin
				if (stat.out_free) state_d = stat.res_last ? S_IDLE : S_SC_CH;
			end
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		unique case (state_q)
			S_SWEEP_RST: cmd.op = OP_SWEEP;
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_ACCEPT;
			end
			S_CLR:       cmd.op = OP_CLR;
			S_SWEEP_CLR: cmd.op = OP_SWEEP;
			S_EMIT:      cmd.op = OP_EMIT;
			S_ADD:       cmd.op = OP_ADD;
			S_ADD_EV:    cmd.op = OP_ADD_EV;
			S_ADD_OWN:   cmd.op = OP_ADD_OWN;
			S_B0:        cmd.op = OP_B0;
			S_B1_RD:     cmd.op = OP_B1_RD;
			S_B1_EV:     cmd.op = OP_B1_EV;
			S_B2_POP:    cmd.op = OP_B2_POP;
			S_B2_R:      cmd.op = OP_B2_R;
			S_B2_FR:     cmd.op = OP_B2_FR;
			S_B2_RD:     cmd.op = OP_B2_RD;
			S_B2_EV:     cmd.op = OP_B2_EV;
			S_B2_NEXT:   cmd.op = OP_B2_NEXT;
			S_B2_WALK:   cmd.op = OP_B2_WALK;
			S_B2_FAIL:   cmd.op = OP_B2_FAIL;
			S_B2_OUT:    cmd.op = OP_B2_OUT;
			S_SC:        cmd.op = OP_SC;
			S_SC_EV:     cmd.op = OP_SC_EV;
			S_SC_FAIL:   cmd.op = OP_SC_FAIL;
			S_SC_OWN:    cmd.op = OP_SC_OWN;
			S_SC_CH:     cmd.op = OP_SC_CH;
			S_EMIT_M:    cmd.op = OP_EMIT_M;
			default:     cmd.op = OP_NONE;
		endcase
	end

endmodule

>>> rtl/core/mpsm_datapath.sv
// ----------------------------------------------------------------------------
// mpsm_datapath: tables, registers and result register of the matcher
// Holds the goto, failure, pattern, output-link and queue memories and
// carries out one micro-operation per cycle as commanded.
// ----------------------------------------------------------------------------
module mpsm_datapath import mpsm_pkg::*; #(
	parameter int STATES   = 256,
	parameter int ALPHABET = 256,
	parameter int PATTERNS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cmd_t            cmd,
	output stat_t           stat,
	input  logic [7:0]      data_byte,
	input  logic            pattern_end,
	output logic            out_valid,
	input  logic            out_ready,
	output status_t         out_status,
	output logic [ID_W-1:0] out_id,
	output logic            out_last
);

	localparam int SW  = $clog2(STATES);
	localparam int SVW = $clog2(STATES + 1);
	localparam int AW  = $clog2(ALPHABET);
	localparam int GAW = SW + AW;
	localparam int GD  = STATES * (2 ** AW);
	localparam int PVW = $clog2(PATTERNS + 1);
	localparam logic [SVW-1:0] ABSENT = SVW'(STATES);
	localparam logic [PVW-1:0] NO_PAT = PVW'(PATTERNS);

	// Reduce a byte modulo the alphabet size by restoring subtraction.
	function automatic logic [7:0] fold_byte(input logic [7:0] b);
		logic [7:0]  v;
		logic [16:0] d;
		v = b;
		for (int k = 7; k >= 0; k--) begin
			d = 17'(ALPHABET) << k;
			if ({9'd0, v} >= d) v = v - d[7:0];
		end
		return v;
	endfunction

	logic [GAW-1:0]    sweep_q;
	logic [SW-1:0]     cursor_q, scan_q, head_q, tail_q;
	logic [SW-1:0]     r_q, fr_q, s_q, st_q, f_q, link_q;
	logic [SVW-1:0]    next_free_q;
	logic [PVW-1:0]    pcount_q;
	logic              built_q, dropped_q, last_q;
	logic [AW-1:0]     chr_q, c_q;
	logic [NCNT_W-1:0] n_q;
	status_t           res_status_q;
	logic [ID_W-1:0]   res_id_q;
	logic              res_last_q;
	logic              out_valid_q, out_last_q;
	status_t           out_status_q;
	logic [ID_W-1:0]   out_id_q;

	logic           gt_we, fl_we, op_we, ol_we, q_we;
	logic [GAW-1:0] gt_waddr, gt_raddr;
	logic [SVW-1:0] gt_wdata, gt_rd;
	logic [SW-1:0]  fl_waddr, fl_wdata, fl_raddr, fl_rd;
	logic [SW-1:0]  op_waddr, ol_waddr, po_raddr;
	logic [PVW-1:0] op_wdata, op_rd;
	logic [SVW-1:0] ol_wdata, ol_rd;
	logic [SW-1:0]  q_waddr, q_wdata, q_raddr, q_rd;

	logic [SW-1:0] g_idx, newcur;
	logic          g_absent, nf_full, own_none, link_none, out_free, sweep_row;

	assign g_idx     = gt_rd[SW-1:0];
	assign g_absent  = (gt_rd == ABSENT);
	assign nf_full   = (next_free_q >= ABSENT);
	assign own_none  = (op_rd == NO_PAT);
	assign link_none = (ol_rd == ABSENT);
	assign out_free  = !out_valid_q || out_ready;
	assign sweep_row = (sweep_q[AW-1:0] == '0);
	assign newcur    = g_absent ? (nf_full ? cursor_q : next_free_q[SW-1:0]) : g_idx;

	assign stat.sweep_done = (sweep_q == GAW'(GD - 1));
	assign stat.built      = built_q;
	assign stat.dropped    = dropped_q;
	assign stat.add_drop   = g_absent && nf_full;
	assign stat.last       = last_q;
	assign stat.q_empty    = (head_q == tail_q);
	assign stat.chr_last   = (chr_q == AW'(ALPHABET - 1));
	assign stat.g_absent   = g_absent;
	assign stat.own_none   = own_none;
	assign stat.link_none  = link_none;
	assign stat.res_last   = res_last_q;
	assign stat.out_free   = out_free;

	// Memory port steering.
	always_comb begin
		gt_we = 1'b0; gt_waddr = '0; gt_wdata = '0; gt_raddr = '0;
		fl_we = 1'b0; fl_waddr = '0; fl_wdata = '0; fl_raddr = '0;
		op_we = 1'b0; op_waddr = '0; op_wdata = '0;
		ol_we = 1'b0; ol_waddr = '0; ol_wdata = '0; po_raddr = '0;
		q_we  = 1'b0; q_waddr  = '0; q_wdata  = '0; q_raddr  = '0;
		case (cmd.op)
			OP_SWEEP: begin
				gt_we = 1'b1; gt_waddr = sweep_q; gt_wdata = ABSENT;
				fl_we = sweep_row; fl_waddr = sweep_q[GAW-1:AW];
				op_we = sweep_row; op_waddr = sweep_q[GAW-1:AW]; op_wdata = NO_PAT;
				ol_we = sweep_row; ol_waddr = sweep_q[GAW-1:AW]; ol_wdata = ABSENT;
			end
			OP_ADD: gt_raddr = {cursor_q, c_q};
			OP_ADD_EV: begin
				gt_we    = g_absent && !nf_full;
				gt_waddr = {cursor_q, c_q};
				gt_wdata = next_free_q;
				po_raddr = newcur;
			end
			OP_ADD_OWN: begin
				op_we    = own_none && (pcount_q < NO_PAT);
				op_waddr = cursor_q;
				op_wdata = pcount_q;
			end
			OP_B1_RD: gt_raddr = {SW'(0), chr_q};
			OP_B1_EV: begin
				gt_we    = g_absent;
				gt_waddr = {SW'(0), chr_q};
				fl_we    = !g_absent && (g_idx != '0);
				fl_waddr = g_idx;
				ol_we    = fl_we; ol_waddr = g_idx; ol_wdata = ABSENT;
				q_we     = fl_we; q_waddr  = tail_q; q_wdata = g_idx;
			end
			OP_B2_POP: q_raddr = head_q;
			OP_B2_R:   fl_raddr = q_rd;
			OP_B2_RD:  gt_raddr = {r_q, chr_q};
			OP_B2_EV: begin
				gt_raddr = {fr_q, chr_q};
				q_we = !g_absent; q_waddr = tail_q; q_wdata = g_idx;
			end
			OP_B2_WALK: begin
				fl_raddr = st_q;
				fl_we = !g_absent; fl_waddr = s_q; fl_wdata = g_idx;
				po_raddr = g_idx;
			end
			OP_B2_FAIL: gt_raddr = {fl_rd, chr_q};
			OP_B2_OUT: begin
				ol_we    = 1'b1;
				ol_waddr = s_q;
				ol_wdata = own_none ? ol_rd : SVW'(f_q);
			end
			OP_SC:      gt_raddr = {scan_q, c_q};
			OP_SC_EV: begin
				fl_raddr = st_q;
				po_raddr = g_idx;
			end
			OP_SC_FAIL: gt_raddr = {fl_rd, c_q};
			OP_SC_OWN:  po_raddr = ol_rd[SW-1:0];
			OP_EMIT_M:  po_raddr = link_q;
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			cursor_q    <= '0;
			next_free_q <= SVW'(1);
			pcount_q    <= '0;
			built_q     <= 1'b0;
			dropped_q   <= 1'b0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_CLR: begin
					sweep_q     <= '0;
					cursor_q    <= '0;
					next_free_q <= SVW'(1);
					pcount_q    <= '0;
					built_q     <= 1'b0;
					dropped_q   <= 1'b0;
					scan_q      <= '0;
				end
				OP_SWEEP: sweep_q <= sweep_q + 1'b1;
				OP_ADD: begin
					if (!built_q && dropped_q && last_q) begin
						cursor_q  <= '0;
						dropped_q <= 1'b0;
					end
				end
				OP_ADD_EV: begin
					if (g_absent && nf_full) begin
						if (last_q) cursor_q <= '0;
						else dropped_q <= 1'b1;
					end else begin
						cursor_q <= newcur;
						if (g_absent) next_free_q <= next_free_q + 1'b1;
					end
				end
				OP_ADD_OWN: begin
					if (own_none && (pcount_q < NO_PAT)) pcount_q <= pcount_q + 1'b1;
					cursor_q  <= '0;
					dropped_q <= 1'b0;
				end
				OP_B0: begin
					if (!built_q) begin
						cursor_q  <= '0;
						dropped_q <= 1'b0;
					end
				end
				OP_B2_POP: if (head_q == tail_q) built_q <= 1'b1;
				OP_SC_EV:  if (!g_absent) scan_q <= g_idx;
				default: ;
			endcase
			if ((cmd.op == OP_EMIT || cmd.op == OP_EMIT_M) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				c_q          <= AW'(fold_byte(data_byte));
				last_q       <= pattern_end;
				res_status_q <= ST_OK;
				res_id_q     <= '0;
				res_last_q   <= 1'b1;
			end
			OP_ADD: begin
				if (built_q) res_status_q <= ST_WRONG_PHASE;
				else if (dropped_q) res_status_q <= ST_STATES_FULL;
			end
			OP_ADD_EV:  if (g_absent && nf_full) res_status_q <= ST_STATES_FULL;
			OP_ADD_OWN: if (own_none && !(pcount_q < NO_PAT)) res_status_q <= ST_PATTERNS_FULL;
			OP_B0: begin
				if (built_q) res_status_q <= ST_WRONG_PHASE;
				chr_q  <= '0;
				head_q <= '0;
				tail_q <= '0;
			end
			OP_B1_EV: begin
				chr_q <= chr_q + 1'b1;
				if (!g_absent && (g_idx != '0)) tail_q <= tail_q + 1'b1;
			end
			OP_B2_POP:  if (head_q != tail_q) head_q <= head_q + 1'b1;
			OP_B2_R:    r_q <= q_rd;
			OP_B2_FR: begin
				fr_q  <= fl_rd;
				chr_q <= '0;
			end
			OP_B2_NEXT: chr_q <= chr_q + 1'b1;
			OP_B2_EV: begin
				if (!g_absent) begin
					s_q    <= g_idx;
					tail_q <= tail_q + 1'b1;
					st_q   <= fr_q;
				end
			end
			OP_B2_WALK: f_q  <= g_idx;
			OP_B2_FAIL: st_q <= fl_rd;
			OP_SC: begin
				if (!built_q) res_status_q <= ST_WRONG_PHASE;
				st_q <= scan_q;
				n_q  <= '0;
			end
			OP_SC_EV:   if (!g_absent) st_q <= g_idx;
			OP_SC_FAIL: st_q <= fl_rd;
			OP_SC_OWN: begin
				link_q <= ol_rd[SW-1:0];
				if (!own_none) begin
					res_status_q <= ST_MATCH;
					res_id_q     <= ID_W'(op_rd);
					res_last_q   <= link_none;
					n_q          <= NCNT_W'(1);
				end else begin
					res_status_q <= ST_NOMATCH;
					res_last_q   <= 1'b1;
				end
			end
			OP_SC_CH: begin
				link_q       <= ol_rd[SW-1:0];
				res_status_q <= ST_MATCH;
				res_id_q     <= ID_W'(op_rd);
				res_last_q   <= link_none || (n_q == NCNT_W'(MAX_RESULTS - 1));
				n_q          <= n_q + 1'b1;
			end
			OP_EMIT, OP_EMIT_M: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_id_q     <= res_id_q;
					out_last_q   <= res_last_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_id     = out_id_q;
	assign out_last   = out_last_q;

	mpsm_ram #(.WIDTH(SVW), .DEPTH(GD)) u_goto (
		.clk(clk), .we(gt_we), .waddr(gt_waddr), .wdata(gt_wdata),
		.raddr(gt_raddr), .rdata(gt_rd)
	);

	mpsm_ram #(.WIDTH(SW), .DEPTH(STATES)) u_fail (
		.clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
		.raddr(fl_raddr), .rdata(fl_rd)
	);

	mpsm_ram #(.WIDTH(PVW), .DEPTH(STATES)) u_own (
		.clk(clk), .we(op_we), .waddr(op_waddr), .wdata(op_wdata),
		.raddr(po_raddr), .rdata(op_rd)
	);

	mpsm_ram #(.WIDTH(SVW), .DEPTH(STATES)) u_olink (
		.clk(clk), .we(ol_we), .waddr(ol_waddr), .wdata(ol_wdata),
		.raddr(po_raddr), .rdata(ol_rd)
	);

	mpsm_ram #(.WIDTH(SW), .DEPTH(STATES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rd)
	);

endmodule

>>> rtl/core/multi_pattern_string_matcher_core.sv
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher_core: keyword automaton build and scan engine
// Adds pattern bytes to a goto trie, builds failure and output links
// breadth-first, then scans text bytes and reports every pattern ending at
// each byte.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents
//   s_*      in         tuser[1:0] action, tdata[7:0] data_byte, tlast pattern_end
//   m_*      out        tdata[2:0] status, tdata[6:3] pattern_id, tlast last_result
//
// One input beat is taken at a time; the engine works on it until all of its
// results have been handed to the output register. Add, scan and build items
// are paced by the one-read-per-cycle goto memory: an add item takes an extra
// step on a pattern's final byte, a scan byte extra steps per failure step and
// per extra match, and a build walks the root row and then every queued trie
// state. After reset, and in every clear item, a clearing pass writes all
// STATES * 2**ceil(log2(ALPHABET)) goto entries (65536 at the default sizes),
// with s_tready low; a clear item answers once its pass is done. A stalled
// receiver holds the engine in its result step until the output register
// frees. The output register lets a new input beat be accepted while a
// result waits.
module multi_pattern_string_matcher_core import mpsm_pkg::*; #(
	parameter int STATES   = 256,
	parameter int ALPHABET = 256,
	parameter int PATTERNS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic [1:0] s_tuser,   // [1:0] action
	input  logic       s_tlast,   // pattern_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [2:0] status, [6:3] pattern_id, [7] zero
	output logic       m_tlast    // last_result
);

	cmd_t            cmd;
	stat_t           stat;
	status_t         out_status;
	logic [ID_W-1:0] out_id;

	// The controller sequences each item; the datapath owns all storage.
	mpsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (action_t'(s_tuser)),
		.in_ready  (s_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mpsm_datapath #(
		.STATES   (STATES),
		.ALPHABET (ALPHABET),
		.PATTERNS (PATTERNS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.data_byte   (s_tdata),
		.pattern_end (s_tlast),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (out_status),
		.out_id      (out_id),
		.out_last    (m_tlast)
	);

	// Pack the result beat, first field in the lowest bits.
	assign m_tdata = {1'b0, out_id, out_status};

endmodule

>>> test/mpsm_checker.sv
// ----------------------------------------------------------------------------
// mpsm_checker: result predictor and comparator for the string matcher
// Watches both stream channels, keeps its own copy of the keyword automaton,
// predicts the result beats of every accepted input beat and compares them.
// ----------------------------------------------------------------------------
module mpsm_checker import mpsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic [1:0] s_tuser,
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tlast,
	output int         fails,
	output int         pending
);

	localparam int N_ST    = 256;
	localparam int N_SYM   = 256;
	localparam int N_PAT   = 16;
	localparam int ABSENT  = N_ST;
	localparam int NO_PAT  = N_PAT;
	localparam int NO_LINK = N_ST;

	typedef struct {
		status_t    status;
		logic [3:0] id;
		logic       last;
	} match_beat_t;

	match_beat_t expected_beats[$];

	int unsigned trie[0:N_ST*N_SYM-1];
	int unsigned fail_of[0:N_ST-1];
	int unsigned pat_of[0:N_ST-1];
	int unsigned dict_of[0:N_ST-1];
	int unsigned free_state, cursor, text_state, pat_total;
	bit          linked, discarding;

	task automatic report(input string what);
		$display("ERROR @%0t: %s", $time, what);
		fails++;
	endtask

	function automatic void clear_automaton();
		for (int i = 0; i < N_ST*N_SYM; i++)
			trie[i] = ABSENT;
		for (int i = 0; i < N_ST; i++) begin
			fail_of[i] = 0;
			pat_of[i]  = NO_PAT;
			dict_of[i] = NO_LINK;
		end
		free_state = 1;
		cursor     = 0;
		text_state = 0;
		pat_total  = 0;
		linked     = 0;
		discarding = 0;
	endfunction

	function automatic void push_beat(input status_t st, input int unsigned id,
			input logic lst);
		match_beat_t b;
		b.status = st;
		b.id     = id[3:0];
		b.last   = lst;
		expected_beats.insert(expected_beats.size(), b);
	endfunction

	function automatic status_t insert_byte(input int unsigned c, input bit lst);
		status_t     st;
		int unsigned nxt;
		st = ST_OK;
		if (linked)
			return ST_WRONG_PHASE;
		if (discarding) begin
			st = ST_STATES_FULL;
		end else begin
			nxt = trie[cursor*N_SYM + c];
			if (nxt == ABSENT) begin
				if (free_state >= N_ST) begin
					discarding = 1;
					st = ST_STATES_FULL;
				end else begin
					trie[cursor*N_SYM + c] = free_state;
					cursor = free_state;
					free_state++;
				end
			end else begin
				cursor = nxt;
			end
		end
		if (lst) begin
			if (!discarding && pat_of[cursor] == NO_PAT) begin
				if (pat_total >= N_PAT)
					st = ST_PATTERNS_FULL;
				else
					pat_of[cursor] = pat_total++;
			end
			cursor     = 0;
			discarding = 0;
		end
		return st;
	endfunction

	function automatic status_t link_automaton();
		int unsigned fifo[$];
		int unsigned r, s, f, w;
		if (linked)
			return ST_WRONG_PHASE;
		cursor     = 0;
		discarding = 0;
		for (int c = 0; c < N_SYM; c++) begin
			s = trie[c];
			if (s == ABSENT) begin
				trie[c] = 0;
			end else if (s != 0) begin
				fail_of[s] = 0;
				dict_of[s] = NO_LINK;
				fifo.insert(fifo.size(), s);
			end
		end
		while (fifo.size() != 0) begin
			r = fifo[0];
			fifo.delete(0);
			for (int c = 0; c < N_SYM; c++) begin
				s = trie[r*N_SYM + c];
				if (s == ABSENT)
					continue;
				fifo.insert(fifo.size(), s);
				w = fail_of[r];
				while (trie[w*N_SYM + c] == ABSENT)
					w = fail_of[w];
				f = trie[w*N_SYM + c];
				fail_of[s] = f;
				dict_of[s] = (pat_of[f] != NO_PAT) ? f : dict_of[f];
			end
		end
		linked = 1;
		return ST_OK;
	endfunction

	// Works out every result beat of one input beat and queues them in order.
	function automatic void predict_matches(input action_t act, input int unsigned c,
			input bit lst);
		int unsigned w, lnk;
		int          n;
		case (act)
			ACT_CLEAR: begin
				clear_automaton();
				push_beat(ST_OK, 0, 1);
			end
			ACT_ADD:   push_beat(insert_byte(c, lst), 0, 1);
			ACT_BUILD: push_beat(link_automaton(), 0, 1);
			default: begin
				if (!linked) begin
					push_beat(ST_WRONG_PHASE, 0, 1);
				end else begin
					w = text_state;
					while (trie[w*N_SYM + c] == ABSENT)
						w = fail_of[w];
					w = trie[w*N_SYM + c];
					text_state = w;
					n = 0;
					if (pat_of[w] != NO_PAT) begin
						push_beat(ST_MATCH, pat_of[w], 0);
						n++;
					end
					lnk = dict_of[w];
					for (int g = 0; lnk != NO_LINK && n < MAX_RESULTS && g < N_ST; g++) begin
						push_beat(ST_MATCH, pat_of[lnk], 0);
						n++;
						lnk = dict_of[lnk];
					end
					if (n == 0)
						push_beat(ST_NOMATCH, 0, 1);
					else
						expected_beats[expected_beats.size()-1].last = 1;
				end
			end
		endcase
	endfunction

	initial begin
		fails   = 0;
		pending = 0;
		clear_automaton();
	end

	always @(posedge clk) begin
		match_beat_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_matches(action_t'(s_tuser), {24'd0, s_tdata}, s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_beats.size() == 0) begin
					report($sformatf("unexpected result beat tdata=%h", m_tdata));
				end else begin
					want = expected_beats[0];
					expected_beats.delete(0);
					if (m_tdata[2:0] != want.status)
						report($sformatf("status %0d, wanted %0d", m_tdata[2:0], want.status));
					if (m_tdata[6:3] != want.id)
						report($sformatf("pattern id %0d, wanted %0d", m_tdata[6:3], want.id));
					if (m_tdata[7] != 1'b0)
						report("padding bit of result set");
					if (m_tlast != want.last)
						report($sformatf("last flag %0b, wanted %0b", m_tlast, want.last));
				end
			end
			pending <= expected_beats.size();
		end
	end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the multi-pattern string matcher
// Drives pattern, build and scan beats in sessions separated by clears, with
// random gaps on both channels; a checker beside the block predicts results.
// ----------------------------------------------------------------------------
module tb_top;
	import mpsm_pkg::*;

	// Every clear costs a sweep over all 65536 goto entries and a full trie
	// build is long as well, so the limit leaves wide margin over the slowest run.
	localparam int LIMIT = 4_000_000;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       s_tvalid = 0;
	logic       s_tready;
	logic [7:0] s_tdata = 0;
	logic [1:0] s_tuser = 0;
	logic       s_tlast = 0;
	logic       m_tvalid;
	logic       m_tready = 0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	int fails, pending;
	int cycles = 0;
	bit calm = 0;   // while set, neither side inserts gaps or stalls

	always #10 clk = ~clk;

	multi_pattern_string_matcher_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	mpsm_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .fails(fails), .pending(pending)
	);

	// The receiver stalls at random in about a fifth of the cycles.
	always @(posedge clk)
		m_tready <= calm || ($urandom_range(99) >= 21);

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Presents one beat and returns at the edge where it is taken. Gaps are
	// inserted before the beat, so valid never drops and rises in one step.
	task automatic send_beat(input action_t act, input logic [7:0] b, input logic lst);
		while (!calm && $urandom_range(99) < 21) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= b;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic add_pattern(input string p);
		for (int i = 0; i < p.len(); i++)
			send_beat(ACT_ADD, p[i], i == p.len() - 1);
	endtask

	task automatic scan_text(input string t);
		for (int i = 0; i < t.len(); i++)
			send_beat(ACT_SCAN, t[i], 1'($urandom_range(1)));
	endtask

	// Short patterns over a three-letter alphabet make matches and long
	// output chains common; a few bytes from the full range mix in.
	function automatic logic [7:0] rand_sym();
		if ($urandom_range(9) == 0)
			return 8'($urandom_range(255));
		return 8'h61 + 8'($urandom_range(2));
	endfunction

	task automatic random_session();
		int np, len;
		send_beat(ACT_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
		np = $urandom_range(3, 10);
		for (int p = 0; p < np; p++) begin
			len = $urandom_range(1, 4);
			for (int i = 0; i < len; i++)
				send_beat(ACT_ADD, rand_sym(), i == len - 1);
			if ($urandom_range(19) == 0)
				send_beat(ACT_SCAN, rand_sym(), 1'($urandom_range(1)));
		end
		send_beat(ACT_BUILD, 8'($urandom_range(255)), 1'($urandom_range(1)));
		for (int i = 0; i < 20; i++) begin
			case ($urandom_range(19))
				0:       send_beat(ACT_ADD, rand_sym(), 1'($urandom_range(1)));
				1:       send_beat(ACT_BUILD, 8'($urandom_range(255)),
						1'($urandom_range(1)));
				default: send_beat(ACT_SCAN, rand_sym(), 1'($urandom_range(1)));
			endcase
		end
	endtask

	initial begin
		string chain;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed session: the classic keyword set, a duplicate, the byte
		// extremes, pattern table overflow and an unfinished pattern.
		send_beat(ACT_SCAN, 8'h61, 1'b0);            // scan before build
		add_pattern("he");
		add_pattern("she");
		add_pattern("his");
		add_pattern("hers");
		add_pattern("he");                           // duplicate is ignored
		send_beat(ACT_ADD, 8'h00, 1'b0);
		send_beat(ACT_ADD, 8'hFF, 1'b1);
		add_pattern("a");
		add_pattern("b");
		add_pattern("c");
		add_pattern("d");
		add_pattern("e");
		add_pattern("f");
		add_pattern("g");
		add_pattern("h");
		add_pattern("i");
		add_pattern("j");
		add_pattern("k");                            // sixteenth pattern
		add_pattern("z");                            // table already full
		send_beat(ACT_ADD, 8'h78, 1'b0);             // left unfinished
		send_beat(ACT_BUILD, 8'h00, 1'b0);
		send_beat(ACT_BUILD, 8'hFF, 1'b1);           // second build refused
		send_beat(ACT_ADD, 8'h61, 1'b1);             // add after build refused
		scan_text("ushers");
		send_beat(ACT_SCAN, 8'h00, 1'b1);
		send_beat(ACT_SCAN, 8'hFF, 1'b0);
		send_beat(ACT_SCAN, 8'h7A, 1'b0);

		// Run out of trie states with one pattern covering every byte value.
		send_beat(ACT_CLEAR, 8'hFF, 1'b1);
		for (int i = 0; i < 256; i++)
			send_beat(ACT_ADD, 8'(i), 1'b0);
		send_beat(ACT_ADD, 8'h01, 1'b1);             // discarded tail ends
		add_pattern("q");                            // needs a new state
		send_beat(ACT_ADD, 8'h00, 1'b1);             // existing edge registers
		send_beat(ACT_BUILD, 8'h00, 1'b0);
		for (int i = 0; i < 12; i++)
			send_beat(ACT_SCAN, 8'(i), 1'($urandom_range(1)));

		// Sixteen nested patterns give the longest output chain; both sides
		// run without gaps here.
		calm = 1;
		send_beat(ACT_CLEAR, 8'h00, 1'b0);
		chain = "";
		for (int k = 0; k < 16; k++) begin
			chain = {chain, "a"};
			add_pattern(chain);
		end
		send_beat(ACT_BUILD, 8'h00, 1'b0);
		scan_text("aaaaaaaaaaaaaaaaaaaab");
		calm = 0;

		random_session();

		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
